// ----- hw/rtl/rlgg_pkg.sv -----
// Shared types and constants of the grayscale pixel path.
package rlgg_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned TableAw    = $clog2(TableDepth);
  localparam int unsigned LinWidth   = 16;
  localparam int unsigned WeightFrac = 15;
  localparam int unsigned GrayWidth  = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [LinWidth-1:0]  LinMax  = 16'hFFFF;
  localparam logic [GrayWidth-1:0] GrayMax = 8'd255;

  localparam logic [15:0] WeightRedRst   = 16'd6966;
  localparam logic [15:0] WeightGreenRst = 16'd23436;
  localparam logic [15:0] WeightBlueRst  = 16'd2366;

  typedef enum logic [1:0] {
    FN_LOAD_DECODE = 2'd0,
    FN_LOAD_ENCODE = 2'd1,
    FN_CONVERT     = 2'd2,
    FN_FINALIZE    = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WEIGHT_RED    = 3'd0,
    CFG_WEIGHT_GREEN  = 3'd1,
    CFG_WEIGHT_BLUE   = 3'd2,
    CFG_LINEAR_MODE   = 3'd3,
    CFG_INVERT_OUTPUT = 3'd4,
    CFG_GRAY_SOURCE   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] weight_red;
    logic [15:0] weight_green;
    logic [15:0] weight_blue;
    logic        linear_mode;
    logic        invert_output;
    logic        gray_source;
  } cfg_t;

  // Side information that travels with a word behind the decode stage.
  typedef struct packed {
    func_e                func;
    logic [GrayWidth-1:0] inten;
    logic [TableAw-1:0]   idx;
    logic [GrayWidth-1:0] val;
    logic                 row_end;
  } side_t;

endpackage

// ----- hw/rtl/rlgg_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module rlgg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/rlgg_cfg.sv -----
// Configuration register file of the grayscale pixel path.
module rlgg_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rlgg_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rlgg_pkg::CfgDataW-1:0]   cfg_data_i,
  output rlgg_pkg::cfg_t                  cfg_o
);
  import rlgg_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WEIGHT_RED:    cfg_d.weight_red    = cfg_data_i;
        CFG_WEIGHT_GREEN:  cfg_d.weight_green  = cfg_data_i;
        CFG_WEIGHT_BLUE:   cfg_d.weight_blue   = cfg_data_i;
        CFG_LINEAR_MODE:   cfg_d.linear_mode   = cfg_data_i[0];
        CFG_INVERT_OUTPUT: cfg_d.invert_output = cfg_data_i[0];
        CFG_GRAY_SOURCE:   cfg_d.gray_source   = cfg_data_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight_red    <= WeightRedRst;
      cfg_q.weight_green  <= WeightGreenRst;
      cfg_q.weight_blue   <= WeightBlueRst;
      cfg_q.linear_mode   <= 1'b1;
      cfg_q.invert_output <= 1'b0;
      cfg_q.gray_source   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

endmodule

// ----- hw/rtl/rlgg_luma.sv -----
// Weighted luma products, their sum and saturation to a linear high byte.
module rlgg_luma (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  rlgg_pkg::cfg_t                    cfg_i,
  input  logic [rlgg_pkg::LinWidth-1:0]     dec_r_i,
  input  logic [rlgg_pkg::LinWidth-1:0]     dec_g_i,
  input  logic [rlgg_pkg::LinWidth-1:0]     dec_b_i,
  output logic [rlgg_pkg::GrayWidth-1:0]    lin_hi_o
);
  import rlgg_pkg::*;

  localparam int unsigned ProdW = 2 * LinWidth;
  localparam int unsigned SumW  = ProdW + 2;
  localparam int unsigned ShW   = SumW - WeightFrac;

  logic [ProdW-1:0] mul_r, mul_g, mul_b;
  logic [ProdW-1:0] prod_r_q, prod_g_q, prod_b_q;
  logic [SumW-1:0]  sum;
  logic [ShW-1:0]   shifted;
  logic [LinWidth-1:0] lin;

  assign mul_r = cfg_i.weight_red   * dec_r_i;
  assign mul_g = cfg_i.weight_green * dec_g_i;
  assign mul_b = cfg_i.weight_blue  * dec_b_i;

  // A gray source is placed pre-scaled so that the shift below returns it unchanged.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (cfg_i.gray_source) begin
        prod_r_q <= {{(ProdW-LinWidth-WeightFrac){1'b0}}, dec_r_i, {WeightFrac{1'b0}}};
        prod_g_q <= '0;
        prod_b_q <= '0;
      end else begin
        prod_r_q <= mul_r;
        prod_g_q <= mul_g;
        prod_b_q <= mul_b;
      end
    end
  end

  assign sum     = SumW'(prod_r_q) + SumW'(prod_g_q) + SumW'(prod_b_q);
  assign shifted = sum[SumW-1:WeightFrac];
  assign lin     = (|shifted[ShW-1:LinWidth]) ? LinMax : shifted[LinWidth-1:0];
  assign lin_hi_o = lin[LinWidth-1:LinWidth-GrayWidth];

endmodule

// ----- hw/rtl/rgb_luma_gamma_grayscale_top.sv -----
// Top level of the grayscale pixel path: pipeline control, tables and output register.
// A convert or finalize word passes, in order, through the input register, decode
// read, multiply, encode read and output registers. Throughput: one word per cycle
// while the output is ready; stages collapse bubbles, so stalls only hold data.
// Reset clears all valid bits and loads the register defaults; the two tables keep no
// reset and hold undefined data until software loads them. Load words give no result.
module rgb_luma_gamma_grayscale_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rlgg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rlgg_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [7:0]                    red_or_gray_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic [7:0]                    intensity_in_i,
  input  logic [7:0]                    entry_index_i,
  input  logic [15:0]                   entry_value_i,
  input  logic                          row_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    gray_value_o,
  output logic                          row_end_out_o
);
  import rlgg_pkg::*;

  cfg_t cfg;

  // Stage valid bits: input register, decode data, products, encode data, output.
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  // A stage may load when it is empty or its word moves on in the same cycle.
  logic rdy1, rdy2, rdy3, rdy4, rdyo;

  // Stage one: the accepted word as it arrived.
  func_e                func1_q;
  logic [TableAw-1:0]   red1_q, green1_q, blue1_q, idx1_q;
  logic [GrayWidth-1:0] inten1_q;
  logic [LinWidth-1:0]  val1_q;
  logic                 row_end1_q;

  side_t side2_q, side3_q, side4_q;
  logic [LinWidth-1:0]  dec_r, dec_g, dec_b;
  logic [GrayWidth-1:0] lin_hi3;
  logic [GrayWidth-1:0] lin_hi4_q;
  logic [GrayWidth-1:0] enc_rd;
  logic [TableAw-1:0]   enc_raddr;
  logic                 dec_we, enc_we;

  logic [GrayWidth-1:0] fin_gray;
  logic [GrayWidth-1:0] res_d, gray_q;
  logic                 row_end_q;

  rlgg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Ready chain from the output register back to the input.
  assign rdyo = !vo_q || out_ready_i;
  assign rdy4 = !v4_q || rdyo;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      // Decode loads finish when they leave stage one.
      if (rdy2) begin
        v2_q <= v1_q && (func1_q != FN_LOAD_DECODE);
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      // Encode loads finish when they leave stage three.
      if (rdy4) begin
        v4_q <= v3_q && (side3_q.func != FN_LOAD_ENCODE);
      end
      if (rdyo) begin
        vo_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      func1_q    <= func_e'(func_i);
      red1_q     <= red_or_gray_i;
      green1_q   <= green_i;
      blue1_q    <= blue_i;
      inten1_q   <= intensity_in_i;
      idx1_q     <= entry_index_i;
      val1_q     <= entry_value_i;
      row_end1_q <= row_end_i;
    end
    if (rdy2) begin
      side2_q.func    <= func1_q;
      side2_q.inten   <= inten1_q;
      side2_q.idx     <= idx1_q;
      side2_q.val     <= val1_q[GrayWidth-1:0];
      side2_q.row_end <= row_end1_q;
    end
    if (rdy3) begin
      side3_q <= side2_q;
    end
    if (rdy4) begin
      side4_q   <= side3_q;
      lin_hi4_q <= lin_hi3;
    end
    if (rdyo) begin
      gray_q    <= res_d;
      row_end_q <= side4_q.row_end;
    end
  end

  // Three copies of the decode table, one per colour channel, all loaded together.
  // Loads and reads both happen as words leave stage one, so they stay in order.
  assign dec_we = v1_q && (func1_q == FN_LOAD_DECODE) && rdy2;

  rlgg_ram #(.WIDTH(LinWidth), .DEPTH(TableDepth)) u_dec_r (
    .clk_i   (clk_i),
    .we_i    (dec_we),
    .waddr_i (idx1_q),
    .wdata_i (val1_q),
    .re_i    (rdy2),
    .raddr_i (red1_q),
    .rdata_o (dec_r)
  );

  rlgg_ram #(.WIDTH(LinWidth), .DEPTH(TableDepth)) u_dec_g (
    .clk_i   (clk_i),
    .we_i    (dec_we),
    .waddr_i (idx1_q),
    .wdata_i (val1_q),
    .re_i    (rdy2),
    .raddr_i (green1_q),
    .rdata_o (dec_g)
  );

  rlgg_ram #(.WIDTH(LinWidth), .DEPTH(TableDepth)) u_dec_b (
    .clk_i   (clk_i),
    .we_i    (dec_we),
    .waddr_i (idx1_q),
    .wdata_i (val1_q),
    .re_i    (rdy2),
    .raddr_i (blue1_q),
    .rdata_o (dec_b)
  );

  // Products are registered as words enter stage three; the sum is formed after them.
  rlgg_luma u_luma (
    .clk_i    (clk_i),
    .en_i     (rdy3),
    .cfg_i    (cfg),
    .dec_r_i  (dec_r),
    .dec_g_i  (dec_g),
    .dec_b_i  (dec_b),
    .lin_hi_o (lin_hi3)
  );

  // The encode table is both loaded and read as words leave stage three, which keeps
  // loads ordered against the conversions around them.
  assign enc_we    = v3_q && (side3_q.func == FN_LOAD_ENCODE) && rdy4;
  assign enc_raddr = (side3_q.func == FN_FINALIZE) ? side3_q.inten : lin_hi3;

  rlgg_ram #(.WIDTH(GrayWidth), .DEPTH(TableDepth)) u_enc (
    .clk_i   (clk_i),
    .we_i    (enc_we),
    .waddr_i (side3_q.idx),
    .wdata_i (side3_q.val),
    .re_i    (rdy4),
    .raddr_i (enc_raddr),
    .rdata_o (enc_rd)
  );

  // Result selection: a conversion gives the linear byte or its encoding, a finalize
  // gives the encoded or passed intensity, optionally inverted.
  assign fin_gray = cfg.linear_mode ? enc_rd : side4_q.inten;

  always_comb begin
    if (side4_q.func == FN_FINALIZE) begin
      res_d = cfg.invert_output ? GrayMax - fin_gray : fin_gray;
    end else begin
      res_d = cfg.linear_mode ? lin_hi4_q : enc_rd;
    end
  end

  assign out_valid_o   = vo_q;
  assign gray_value_o  = gray_q;
  assign row_end_out_o = row_end_q;

  // Decode loads never travel past stage one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (side2_q.func != FN_LOAD_DECODE))
    else $error("decode load word reached stage two");

  // Only words that give a result reach stage four.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (side4_q.func == FN_CONVERT || side4_q.func == FN_FINALIZE))
    else $error("load word reached stage four");

  // The input is held back only when every stage is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q && vo_q))
    else $error("input stalled while the pipeline has a bubble");

  // Decode read data must hold while stage two is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !rdy2) |=> ($stable(dec_r) && $stable(dec_g) && $stable(dec_b)))
    else $error("decode read data changed during a stall");

endmodule
